// File: src/jsu_pkg.sv
// Shared types, character codes and helper functions for the JSON string unescaper.
package jsu_pkg;

  localparam int unsigned JSU_QUEUE_DEPTH = 4;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_NO_QUOTE     = 3'd1;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd2;
  localparam logic [2:0] ERR_ESC_END      = 3'd3;
  localparam logic [2:0] ERR_HEX_END      = 3'd4;
  localparam logic [2:0] ERR_BAD_HEX      = 3'd5;
  localparam logic [2:0] ERR_BAD_ESC      = 3'd6;

  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_U         = 8'h75;

  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       at_end;
  } jsu_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] error_code;
    logic       last;
  } jsu_out_t;

  // All results of one input item: leading bytes, then an optional done/error.
  typedef struct packed {
    logic [2:0]      nbytes;
    logic [3:0][7:0] bytes;
    logic            term_en;
    logic            term_done;
    logic [2:0]      term_err;
  } jsu_bundle_t;

  typedef struct packed {
    logic [2:0]      cnt;
    logic [3:0][7:0] bytes;
  } jsu_utf8_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } jsu_hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] lit;
  } jsu_lit_t;

  function automatic jsu_utf8_t utf8_encode(input logic [20:0] cp);
    jsu_utf8_t e;
    e = '0;
    if (cp <= 21'h7F) begin
      e.cnt      = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.cnt      = 3'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.cnt      = 3'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.cnt      = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  function automatic jsu_hex_t hex_decode(input logic [7:0] c);
    jsu_hex_t h;
    h = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end
    return h;
  endfunction

  function automatic jsu_lit_t simple_escape(input logic [7:0] c);
    jsu_lit_t r;
    r.ok = 1'b1;
    unique case (c)
      8'h22:   r.lit = 8'h22;
      8'h5C:   r.lit = 8'h5C;
      8'h2F:   r.lit = 8'h2F;
      8'h62:   r.lit = 8'h08;
      8'h66:   r.lit = 8'h0C;
      8'h6E:   r.lit = 8'h0A;
      8'h72:   r.lit = 8'h0D;
      8'h74:   r.lit = 8'h09;
      default: begin
        r.ok  = 1'b0;
        r.lit = 8'h00;
      end
    endcase
    return r;
  endfunction

endpackage

// File: src/jsu_front.sv
// Front end: string parser state machine, turns each input byte into a result bundle.
module jsu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  jsu_pkg::jsu_in_t     in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output jsu_pkg::jsu_bundle_t q_data
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_BODY,
    PH_ESC,
    PH_HEX,
    PH_HIGH,
    PH_HIGH_BS
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [15:0] high_r, high_nxt;
  logic        low_r, low_nxt;

  logic        accept;
  logic [7:0]  c;
  logic        at_end;
  jsu_hex_t    hx;
  jsu_lit_t    sl;
  logic [15:0] v;
  jsu_utf8_t   hi_enc;
  jsu_utf8_t   val_enc;
  logic [20:0] pair_cp;

  // tail actions shared by several phases
  logic        tb_byte_en;
  logic [7:0]  tb_byte;
  logic        tb_term;
  logic        tb_done;
  logic [2:0]  tb_err;
  phase_t      tb_phase;
  logic        te_byte_en;
  logic [7:0]  te_byte;
  logic        te_term;
  logic [2:0]  te_err;
  phase_t      te_phase;
  logic        te_is_u;

  jsu_bundle_t bnd;

  assign c        = in_data.in_byte;
  assign at_end   = in_data.at_end;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hx       = hex_decode(c);
  assign sl       = simple_escape(c);
  assign v        = {acc_r[11:0], hx.val};
  assign hi_enc   = utf8_encode({5'b0, high_r});
  assign pair_cp  = SUPP_BASE + {1'b0, high_r[9:0], v[9:0]};

  // body byte action
  always_comb begin
    tb_byte_en = 1'b0;
    tb_byte    = c;
    tb_term    = 1'b0;
    tb_done    = 1'b0;
    tb_err     = ERR_NONE;
    tb_phase   = PH_BODY;
    if (at_end) begin
      tb_term  = 1'b1;
      tb_err   = ERR_UNTERMINATED;
      tb_phase = PH_WAIT;
    end else if (c == CH_QUOTE) begin
      tb_term  = 1'b1;
      tb_done  = 1'b1;
      tb_phase = PH_WAIT;
    end else if (c == CH_BACKSLASH) begin
      tb_phase = PH_ESC;
    end else begin
      tb_byte_en = 1'b1;
    end
  end

  // escape character action
  always_comb begin
    te_byte_en = 1'b0;
    te_byte    = sl.lit;
    te_term    = 1'b0;
    te_err     = ERR_NONE;
    te_phase   = PH_BODY;
    te_is_u    = 1'b0;
    if (at_end) begin
      te_term  = 1'b1;
      te_err   = ERR_ESC_END;
      te_phase = PH_WAIT;
    end else if (c == CH_U) begin
      te_is_u  = 1'b1;
      te_phase = PH_HEX;
    end else if (sl.ok) begin
      te_byte_en = 1'b1;
    end else begin
      te_term  = 1'b1;
      te_err   = ERR_BAD_ESC;
      te_phase = PH_WAIT;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    bnd       = '0;
    val_enc   = '0;
    unique case (phase_r)
      PH_BODY: begin
        phase_nxt     = tb_phase;
        bnd.nbytes    = {2'b0, tb_byte_en};
        bnd.bytes[0]  = tb_byte;
        bnd.term_en   = tb_term;
        bnd.term_done = tb_done;
        bnd.term_err  = tb_err;
      end
      PH_ESC: begin
        phase_nxt    = te_phase;
        bnd.nbytes   = {2'b0, te_byte_en};
        bnd.bytes[0] = te_byte;
        bnd.term_en  = te_term;
        bnd.term_err = te_err;
        if (te_is_u) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          low_nxt = 1'b0;
        end
      end
      PH_HEX: begin
        if (at_end) begin
          bnd.term_en  = 1'b1;
          bnd.term_err = ERR_HEX_END;
          phase_nxt    = PH_WAIT;
        end else if (!hx.ok) begin
          bnd.term_en  = 1'b1;
          bnd.term_err = ERR_BAD_HEX;
          phase_nxt    = PH_WAIT;
        end else begin
          acc_nxt = v;
          if (cnt_r != 2'd3) begin
            cnt_nxt = cnt_r + 2'd1;
          end else begin
            cnt_nxt = '0;
            if (low_r) begin
              low_nxt = 1'b0;
              if (v >= LOW_MIN && v <= LOW_MAX) begin
                val_enc = utf8_encode(pair_cp);
              end else begin
                val_enc = hi_enc;  // second value is dropped
              end
              bnd.nbytes = val_enc.cnt;
              bnd.bytes  = val_enc.bytes;
              phase_nxt  = PH_BODY;
            end else if (v >= HIGH_MIN && v <= HIGH_MAX) begin
              high_nxt  = v;
              phase_nxt = PH_HIGH;
            end else begin
              val_enc    = utf8_encode({5'b0, v});
              bnd.nbytes = val_enc.cnt;
              bnd.bytes  = val_enc.bytes;
              phase_nxt  = PH_BODY;
            end
          end
        end
      end
      PH_HIGH: begin
        if (!at_end && c == CH_BACKSLASH) begin
          phase_nxt = PH_HIGH_BS;
        end else begin
          // pending high surrogate is always three bytes
          phase_nxt     = tb_phase;
          bnd.bytes     = hi_enc.bytes;
          bnd.bytes[3]  = tb_byte;
          bnd.nbytes    = 3'd3 + {2'b0, tb_byte_en};
          bnd.term_en   = tb_term;
          bnd.term_done = tb_done;
          bnd.term_err  = tb_err;
        end
      end
      PH_HIGH_BS: begin
        if (!at_end && c == CH_U) begin
          acc_nxt   = '0;
          cnt_nxt   = '0;
          low_nxt   = 1'b1;
          phase_nxt = PH_HEX;
        end else begin
          phase_nxt    = te_phase;
          bnd.bytes    = hi_enc.bytes;
          bnd.bytes[3] = te_byte;
          bnd.nbytes   = 3'd3 + {2'b0, te_byte_en};
          bnd.term_en  = te_term;
          bnd.term_err = te_err;
        end
      end
      default: begin
        if (!at_end && c == CH_QUOTE) begin
          phase_nxt = PH_BODY;
          low_nxt   = 1'b0;
          cnt_nxt   = '0;
        end else begin
          phase_nxt    = PH_WAIT;
          bnd.term_en  = 1'b1;
          bnd.term_err = ERR_NO_QUOTE;
        end
      end
    endcase
  end

  assign q_data = bnd;
  assign q_push = accept && ((bnd.nbytes != 3'd0) || bnd.term_en);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT;
      acc_r   <= '0;
      cnt_r   <= '0;
      high_r  <= '0;
      low_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
    end
  end

endmodule

// File: src/jsu_queue.sv
// Small FIFO of result bundles between the parser and the output stage.
module jsu_queue #(
  parameter int unsigned DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  jsu_pkg::jsu_bundle_t push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 empty,
  output jsu_pkg::jsu_bundle_t head
);
  import jsu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_bundle_t   mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// File: src/jsu_back.sv
// Back end: unpacks bundles into single result beats behind an output register.
module jsu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  jsu_pkg::jsu_bundle_t q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output jsu_pkg::jsu_out_t    out_data
);
  import jsu_pkg::*;

  logic [1:0] sel_r;
  logic       out_valid_r;
  jsu_out_t   out_r;
  jsu_out_t   res;
  logic [2:0] total;
  logic       is_byte;
  logic       is_last;
  logic       load;

  assign total   = q_head.nbytes + {2'b0, q_head.term_en};
  assign is_byte = ({1'b0, sel_r} < q_head.nbytes);
  assign is_last = (({1'b0, sel_r} + 3'd1) == total);
  assign load    = !q_empty && (!out_valid_r || out_ready);
  assign q_pop   = load && is_last;

  always_comb begin
    res             = '0;
    res.byte_valid  = is_byte;
    res.out_byte    = is_byte ? q_head.bytes[sel_r] : 8'h00;
    res.string_done = !is_byte && q_head.term_done;
    res.error_code  = is_byte ? ERR_NONE : q_head.term_err;
    res.last        = is_last;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sel_r       <= is_last ? 2'd0 : sel_r + 2'd1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: src/json_string_unescape_utf8_core.sv
// Top level of the JSON string unescaper with UTF-8 output.
// Takes one text byte (or end mark) per cycle whenever the bundle queue has room;
// each byte makes zero to four result beats, which leave one per cycle while
// out_ready is high, so the output port sets the sustained rate. The parser
// decides all results of a byte in the cycle it is accepted and pushes them
// as one bundle into the queue; the first beat then passes through the back
// end's output register. QUEUE_DEPTH bundles can wait between parser and output.
module json_string_unescape_utf8_core #(
  parameter int unsigned QUEUE_DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  jsu_pkg::jsu_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output jsu_pkg::jsu_out_t out_data
);
  import jsu_pkg::*;

  logic        q_push, q_full, q_pop, q_empty;
  jsu_bundle_t q_wdata, q_head;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
